// ===== sv/cssp_pkg.sv =====
// Shared constants and types for the chunked Sklansky prefix sum.
// No dependencies; every other file refers to this package by scoped names.
package cssp_pkg;

  // lanes per chunk and levels of the Sklansky network (log2 of the lane count)
  localparam int Lanes    = 8;
  localparam int LvlCnt   = 3;

  // fixed port field widths
  localparam int InWidth  = 32;
  localparam int OutWidth = 32;
  localparam int CntWidth = 4;

  // per-chunk control that travels with the lane data
  typedef struct packed {
    logic [Lanes-1:0]    mask;        // lanes below lane_count
    logic [CntWidth-1:0] lane_count;  // raw count, copied to the result
    logic                last;        // final chunk of a vector
  } ctrl_t;

endpackage

// ===== sv/cssp_scan_stage.sv =====
// First pipeline stage: lane masking and the eight-lane Sklansky scan network.
// Depends on cssp_pkg; feeds cssp_carry_stage.
module cssp_scan_stage #(
  parameter int ElemWidth = 32
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  reverse_i,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic [cssp_pkg::Lanes-1:0][cssp_pkg::InWidth-1:0]     elem_i,
  input  logic [cssp_pkg::CntWidth-1:0]                         lane_count_i,
  input  logic                                                  last_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [cssp_pkg::Lanes-1:0][ElemWidth-1:0]             lane_o,
  output logic [ElemWidth-1:0]                                  total_o,
  output cssp_pkg::ctrl_t                                       ctrl_o
);

  localparam int CW = cssp_pkg::CntWidth;

  logic [ElemWidth-1:0]               net [cssp_pkg::LvlCnt+1][cssp_pkg::Lanes];
  logic [cssp_pkg::Lanes-1:0]         mask;
  logic [ElemWidth-1:0]               total;

  logic                                        valid_q, valid_d;
  logic [cssp_pkg::Lanes-1:0][ElemWidth-1:0]   lane_q;
  logic [ElemWidth-1:0]                        total_q;
  cssp_pkg::ctrl_t                             ctrl_q;
  logic                                        load;

  // lane mask, sign extension to the element width, unused lanes forced to zero
  for (genvar i = 0; i < cssp_pkg::Lanes; i++) begin : g_in
    assign mask[i]   = (lane_count_i > CW'(i));
    assign net[0][i] = mask[i] ? ElemWidth'(signed'(elem_i[i])) : '0;
  end

  // Sklansky levels: forward adds from the lower half-block, reverse from the upper
  for (genvar l = 0; l < cssp_pkg::LvlCnt; l++) begin : g_lvl
    for (genvar i = 0; i < cssp_pkg::Lanes; i++) begin : g_lane
      localparam int H    = 1 << l;
      localparam int Base = i & ~(2 * H - 1);
      if ((i & H) != 0) begin : g_fwd
        localparam int FwdP = Base + H - 1;
        assign net[l+1][i] = net[l][i] + (reverse_i ? '0 : net[l][FwdP]);
      end else begin : g_rev
        localparam int RevP = Base + H;
        assign net[l+1][i] = net[l][i] + (reverse_i ? net[l][RevP] : '0);
      end
    end
  end

  // chunk total: masked lanes are zero, so the far end of the scan holds it
  assign total = reverse_i ? net[cssp_pkg::LvlCnt][0]
                           : net[cssp_pkg::LvlCnt][cssp_pkg::Lanes-1];

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < cssp_pkg::Lanes; i++) begin
        lane_q[i] <= net[cssp_pkg::LvlCnt][i];
      end
      total_q           <= total;
      ctrl_q.mask       <= mask;
      ctrl_q.lane_count <= lane_count_i;
      ctrl_q.last       <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign lane_o      = lane_q;
  assign total_o     = total_q;
  assign ctrl_o      = ctrl_q;

  // mask is always a run of ones from lane 0
  a_mask_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((ctrl_q.mask & (ctrl_q.mask + 1'b1)) == '0))
    else $error("lane mask not contiguous from lane 0");

  // an empty chunk contributes nothing to the carry
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ctrl_q.mask[0]) |-> (total_q == '0))
    else $error("empty chunk with nonzero total");

  // a stalled chunk stays put
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(total_q)))
    else $error("stalled chunk dropped or changed");

endmodule

// ===== sv/cssp_carry_stage.sv =====
// Second pipeline stage: adds the running carry to each lane and holds the result.
// Depends on cssp_pkg; fed by cssp_scan_stage.
module cssp_carry_stage #(
  parameter int ElemWidth = 32
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic [cssp_pkg::Lanes-1:0][ElemWidth-1:0]             lane_i,
  input  logic [ElemWidth-1:0]                                  total_i,
  input  cssp_pkg::ctrl_t                                       ctrl_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [cssp_pkg::Lanes-1:0][cssp_pkg::OutWidth-1:0]    sum_o,
  output logic [cssp_pkg::CntWidth-1:0]                         lane_count_o,
  output logic                                                  last_o
);

  localparam int OW = cssp_pkg::OutWidth;

  logic                                                valid_q, valid_d;
  logic [ElemWidth-1:0]                                carry_q, carry_d;
  logic [cssp_pkg::Lanes-1:0][ElemWidth-1:0]           lane_sum;
  logic [cssp_pkg::Lanes-1:0][OW-1:0]                  sum_q, sum_d;
  logic [cssp_pkg::CntWidth-1:0]                       cnt_q;
  logic                                                last_q;
  logic                                                load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  // per-lane carry add wrapped at the element width, unused lanes read zero
  always_comb begin
    for (int i = 0; i < cssp_pkg::Lanes; i++) begin
      lane_sum[i] = lane_i[i] + carry_q;
      sum_d[i]    = ctrl_i.mask[i] ? OW'(lane_sum[i]) : '0;
    end
  end

  // carry moves by the chunk total and clears after the final chunk
  always_comb begin
    carry_d = carry_q;
    if (load) begin
      carry_d = ctrl_i.last ? '0 : (carry_q + total_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      carry_q <= carry_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      sum_q  <= sum_d;
      cnt_q  <= ctrl_i.lane_count;
      last_q <= ctrl_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign sum_o        = sum_q;
  assign lane_count_o = cnt_q;
  assign last_o       = last_q;

  // carry is zero after the final chunk passes
  a_carry_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ctrl_i.last) |=> (carry_q == '0))
    else $error("carry not cleared after final chunk");

  // carry only moves on a transfer into this stage
  a_carry_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(carry_q))
    else $error("carry changed without a transfer");

  // top lane reads zero in a partial chunk
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (cnt_q < cssp_pkg::CntWidth'(cssp_pkg::Lanes)))
      |-> (sum_q[cssp_pkg::Lanes-1] == '0))
    else $error("unused lane not zero");

endmodule

// ===== sv/chunked_sklansky_prefix_sum.sv =====
// A chunk is registered in the scan stage and then in the carry stage, whose register
// drives the result channel; back-pressure can hold the chunk in either stage.
// Throughput: one chunk per cycle without back-pressure; the carry loop is a single
// ElemWidth-bit add in the output stage, the three-level scan network sits in the stage before.
// Reset clears the mode register (forward), the running carry and both stage valids.
// Top level of the chunked Sklansky prefix sum; uses cssp_pkg and both stages.
module chunked_sklansky_prefix_sum #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_reverse_mode_i,
  // input chunk channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] elem_0_i,
  input  logic [31:0] elem_1_i,
  input  logic [31:0] elem_2_i,
  input  logic [31:0] elem_3_i,
  input  logic [31:0] elem_4_i,
  input  logic [31:0] elem_5_i,
  input  logic [31:0] elem_6_i,
  input  logic [31:0] elem_7_i,
  input  logic [3:0]  lane_count_i,
  input  logic        end_of_vector_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_0_o,
  output logic [31:0] sum_1_o,
  output logic [31:0] sum_2_o,
  output logic [31:0] sum_3_o,
  output logic [31:0] sum_4_o,
  output logic [31:0] sum_5_o,
  output logic [31:0] sum_6_o,
  output logic [31:0] sum_7_o,
  output logic [3:0]  out_lane_count_o,
  output logic        out_last_o
);

  logic                                                      reverse_q;
  logic [cssp_pkg::Lanes-1:0][cssp_pkg::InWidth-1:0]         elem;
  logic [cssp_pkg::Lanes-1:0][cssp_pkg::OutWidth-1:0]        sum;
  logic                                                      scan_valid, scan_ready;
  logic [cssp_pkg::Lanes-1:0][ELEM_WIDTH-1:0]                scan_lane;
  logic [ELEM_WIDTH-1:0]                                     scan_total;
  cssp_pkg::ctrl_t                                           scan_ctrl;

  // mode register, written on a config transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      reverse_q <= cfg_reverse_mode_i;
    end
  end

  // gather lane ports
  assign elem[0] = elem_0_i;
  assign elem[1] = elem_1_i;
  assign elem[2] = elem_2_i;
  assign elem[3] = elem_3_i;
  assign elem[4] = elem_4_i;
  assign elem[5] = elem_5_i;
  assign elem[6] = elem_6_i;
  assign elem[7] = elem_7_i;

  cssp_scan_stage #(
    .ElemWidth (ELEM_WIDTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reverse_i    (reverse_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .elem_i       (elem),
    .lane_count_i (lane_count_i),
    .last_i       (end_of_vector_i),
    .out_valid_o  (scan_valid),
    .out_ready_i  (scan_ready),
    .lane_o       (scan_lane),
    .total_o      (scan_total),
    .ctrl_o       (scan_ctrl)
  );

  cssp_carry_stage #(
    .ElemWidth (ELEM_WIDTH)
  ) u_carry (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (scan_valid),
    .in_ready_o   (scan_ready),
    .lane_i       (scan_lane),
    .total_i      (scan_total),
    .ctrl_i       (scan_ctrl),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sum_o        (sum),
    .lane_count_o (out_lane_count_o),
    .last_o       (out_last_o)
  );

  // scatter result lanes
  assign sum_0_o = sum[0];
  assign sum_1_o = sum[1];
  assign sum_2_o = sum[2];
  assign sum_3_o = sum[3];
  assign sum_4_o = sum[4];
  assign sum_5_o = sum[5];
  assign sum_6_o = sum[6];
  assign sum_7_o = sum[7];

endmodule
